// File: design/bbr_seq_pkg.sv
`timescale 1ns / 1ps

package bbr_seq_pkg;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_RETRY_LIMIT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BBR_DISABLE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_SHIFT = 2'd2;

    localparam logic [7:0] RETRY_LIMIT_RST = 8'd10;
    localparam logic [4:0] BLOCK_SHIFT_RST = 5'd9;

    localparam int ADDR_WIDTH_DEF = 32;

    // Stream widths, padded to whole bytes
    localparam int S_TDATA_W = 200;
    localparam int M_TDATA_W = 168;

    // Input beat kinds
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_DONE  = 1'b1;

    // Recovery phases
    localparam logic [2:0] PH_IDLE       = 3'd0;
    localparam logic [2:0] PH_COMPLETE   = 3'd1;
    localparam logic [2:0] PH_RETRY_READ = 3'd2;
    localparam logic [2:0] PH_COPY       = 3'd3;
    localparam logic [2:0] PH_VERIFY     = 3'd4;

    // Result actions
    localparam logic [2:0] ACT_DECLINED = 3'd0;
    localparam logic [2:0] ACT_REASSIGN = 3'd1;
    localparam logic [2:0] ACT_READ     = 3'd2;
    localparam logic [2:0] ACT_WRITE    = 3'd3;
    localparam logic [2:0] ACT_RESTART  = 3'd4;
    localparam logic [2:0] ACT_GIVE_UP  = 3'd5;
    localparam logic [2:0] ACT_PROTOCOL = 3'd6;

    typedef struct packed {
        logic [7:0] retry_limit;
        logic       bbr_disable;
        logic [4:0] block_shift;
    } cfg_t;

    typedef struct packed {
        logic        command;
        logic [31:0] bad_block;
        logic        is_read_request;
        logic        is_internal;
        logic [31:0] rec_num;
        logic [31:0] data_addr;
        logic [31:0] byte_count;
        logic [31:0] residual;
        logic        success;
        logic [31:0] part_offset;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] block_no;
        logic [31:0] out_rec_num;
        logic [31:0] out_data_addr;
        logic [31:0] out_byte_count;
        logic [31:0] out_residual;
        logic        read_op;
        logic        clear_error;
        logic        active;
    } res_item_t;

endpackage

// File: design/bbr_seq_in_stage.sv
`timescale 1ns / 1ps

module bbr_seq_in_stage (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  bbr_seq_pkg::in_item_t s_item,
    input  logic                  take,
    output logic                  valid,
    output bbr_seq_pkg::in_item_t item
);
    import bbr_seq_pkg::*;

    logic     valid_reg;
    in_item_t item_reg;

    // Free, or emptying this cycle
    assign s_tready = !valid_reg || take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            valid_reg <= 1'b1;
        end else if (take) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= s_item;
        end
    end

    assign valid = valid_reg;
    assign item  = item_reg;

endmodule

// File: design/bbr_seq_engine.sv
`timescale 1ns / 1ps

module bbr_seq_engine #(
    parameter int ADDR_WIDTH = bbr_seq_pkg::ADDR_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  bbr_seq_pkg::cfg_t      cfg,
    input  logic                   fire,
    input  bbr_seq_pkg::in_item_t  item,
    output bbr_seq_pkg::res_item_t res
);
    import bbr_seq_pkg::*;

    logic [2:0]  phase_reg,   phase_next;
    logic [31:0] bbs_reg,     bbs_next;
    logic [8:0]  retry_reg,   retry_next;
    logic        sread_reg,   sread_next;
    logic [31:0] srec_reg,    srec_next;
    logic [31:0] saddr_reg,   saddr_next;
    logic [31:0] scount_reg,  scount_next;
    logic [31:0] sresid_reg,  sresid_next;
    logic [31:0] wb_rec_reg,  wb_rec_next;
    logic [31:0] wb_addr_reg, wb_addr_next;

    logic [ADDR_WIDTH-1:0] rew_addr_aw;
    logic [ADDR_WIDTH-1:0] wb_addr_aw;
    logic [31:0]           in_addr_m;
    logic [31:0]           saddr_m;
    logic [31:0]           rew_addr;
    logic [31:0]           rew_rec;
    logic [31:0]           rew_count;
    logic [31:0]           wb_rec_calc;
    logic [31:0]           wb_delta;
    logic [31:0]           wb_addr_calc;
    logic [31:0]           blk_bytes;
    logic [8:0]            retry_inc;

    // Address arithmetic wraps at ADDR_WIDTH, results cut to 32 bits
    assign in_addr_m   = 32'(ADDR_WIDTH'(item.data_addr));
    assign saddr_m     = 32'(ADDR_WIDTH'(saddr_reg));
    assign rew_addr_aw = ADDR_WIDTH'(saddr_reg) - ADDR_WIDTH'(sresid_reg);
    assign rew_addr    = 32'(rew_addr_aw);
    assign rew_count   = scount_reg + sresid_reg;
    assign rew_rec     = srec_reg - (sresid_reg >> cfg.block_shift);

    assign wb_rec_calc  = bbs_reg - item.part_offset;
    assign wb_delta     = wb_rec_calc - srec_reg;
    assign wb_addr_aw   = ADDR_WIDTH'(saddr_reg)
                        + (ADDR_WIDTH'(wb_delta) << cfg.block_shift);
    assign wb_addr_calc = 32'(wb_addr_aw);
    assign blk_bytes    = 32'd1 << cfg.block_shift;
    assign retry_inc    = retry_reg + 9'd1;

    always_comb begin
        res_item_t r;
        logic      fin;
        logic      fin_ok;
        logic      fin_clr;

        r            = '0;
        fin          = 1'b0;
        fin_ok       = 1'b0;
        fin_clr      = 1'b0;
        phase_next   = phase_reg;
        bbs_next     = bbs_reg;
        retry_next   = retry_reg;
        sread_next   = sread_reg;
        srec_next    = srec_reg;
        saddr_next   = saddr_reg;
        scount_next  = scount_reg;
        sresid_next  = sresid_reg;
        wb_rec_next  = wb_rec_reg;
        wb_addr_next = wb_addr_reg;

        if (item.command == CMD_START) begin
            if (cfg.bbr_disable || item.is_internal) begin
                r.action = ACT_DECLINED;
            end else begin
                bbs_next    = item.bad_block;
                retry_next  = '0;
                srec_next   = item.rec_num;
                saddr_next  = item.data_addr;
                scount_next = item.byte_count;
                sresid_next = item.residual;
                sread_next  = item.is_read_request;
                r.out_rec_num    = item.rec_num;
                r.out_data_addr  = in_addr_m;
                r.out_byte_count = item.byte_count;
                if (!item.is_read_request) begin
                    phase_next     = PH_COMPLETE;
                    r.action       = ACT_REASSIGN;
                    r.block_no     = item.bad_block;
                    r.out_residual = item.residual;
                end else begin
                    phase_next = PH_RETRY_READ;
                    r.action   = ACT_READ;
                    r.read_op  = 1'b1;
                end
            end
        end else begin
            unique case (phase_reg)
                PH_COMPLETE: begin
                    fin    = 1'b1;
                    fin_ok = item.success;
                end
                PH_RETRY_READ: begin
                    if (item.success) begin
                        retry_next       = '0;
                        phase_next       = PH_COPY;
                        r.action         = ACT_REASSIGN;
                        r.block_no       = bbs_reg;
                        r.out_rec_num    = srec_reg;
                        r.out_data_addr  = saddr_m;
                        r.out_byte_count = scount_reg;
                        r.read_op        = 1'b1;
                    end else begin
                        retry_next = retry_inc;
                        if (retry_reg < {1'b0, cfg.retry_limit}) begin
                            r.action         = ACT_READ;
                            r.out_rec_num    = srec_reg;
                            r.out_data_addr  = saddr_m;
                            r.out_byte_count = scount_reg;
                            r.read_op        = 1'b1;
                        end else begin
                            fin = 1'b1;
                        end
                    end
                end
                PH_COPY: begin
                    if (item.success) begin
                        wb_rec_next      = wb_rec_calc;
                        wb_addr_next     = wb_addr_calc;
                        phase_next       = PH_VERIFY;
                        r.action         = ACT_WRITE;
                        r.out_rec_num    = wb_rec_calc;
                        r.out_data_addr  = wb_addr_calc;
                        r.out_byte_count = blk_bytes;
                    end else begin
                        fin     = 1'b1;
                        fin_clr = 1'b1;
                    end
                end
                PH_VERIFY: begin
                    if (item.success) begin
                        fin    = 1'b1;
                        fin_ok = 1'b1;
                    end else begin
                        retry_next = retry_inc;
                        if (retry_reg > {1'b0, cfg.retry_limit}) begin
                            fin = 1'b1;
                        end else begin
                            r.action         = ACT_WRITE;
                            r.out_rec_num    = wb_rec_reg;
                            r.out_data_addr  = wb_addr_reg;
                            r.out_byte_count = blk_bytes;
                        end
                    end
                end
                default: begin
                    r.action = ACT_PROTOCOL;
                end
            endcase
        end

        // Close the recovery: restart rewound by the residual, or give up
        if (fin) begin
            phase_next = PH_IDLE;
            r.read_op  = sread_reg;
            if (fin_ok) begin
                r.action         = ACT_RESTART;
                r.out_rec_num    = rew_rec;
                r.out_data_addr  = rew_addr;
                r.out_byte_count = rew_count;
                r.out_residual   = '0;
                r.clear_error    = 1'b1;
            end else begin
                r.action         = ACT_GIVE_UP;
                r.out_rec_num    = srec_reg;
                r.out_data_addr  = saddr_m;
                r.out_byte_count = scount_reg;
                r.out_residual   = sresid_reg;
                r.clear_error    = fin_clr;
            end
        end

        r.active = (phase_next != PH_IDLE);
        res      = r;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            bbs_reg   <= '0;
            retry_reg <= '0;
            sread_reg <= 1'b0;
        end else if (fire) begin
            phase_reg <= phase_next;
            bbs_reg   <= bbs_next;
            retry_reg <= retry_next;
            sread_reg <= sread_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            srec_reg    <= srec_next;
            saddr_reg   <= saddr_next;
            scount_reg  <= scount_next;
            sresid_reg  <= sresid_next;
            wb_rec_reg  <= wb_rec_next;
            wb_addr_reg <= wb_addr_next;
        end
    end

endmodule

// File: design/bbr_seq_out_stage.sv
`timescale 1ns / 1ps

module bbr_seq_out_stage (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   load,
    input  bbr_seq_pkg::res_item_t res,
    output logic                   can_load,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output bbr_seq_pkg::res_item_t m_res
);
    import bbr_seq_pkg::*;

    logic      valid_reg;
    res_item_t res_reg;

    // Empty, or the held beat leaves this cycle
    assign can_load = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_res    = res_reg;

endmodule

// File: design/bad_block_replacement_sequencer_core.sv
`timescale 1ns / 1ps

// Channel   Dir  Ports                         Contents
// s_        in   s_tvalid/s_tready/s_tdata/s_tuser  recovery start or completion beat
// m_        out  m_tvalid/m_tready/m_tdata/m_tuser  next action with request fields
// cfg_      in   cfg_wen/cfg_index/cfg_wdata   retry_limit, bbr_disable, block_shift
//
// One beat in per cycle while the m_ side takes results, one result out per beat;
// a beat passes the input register, then the phase logic into the result register.
// The single recovery phase register is updated once per processed beat.
// aresetn is synchronous, active low: phase idle, config registers back to defaults.
// A stalled m_ side holds the result; s_ keeps taking beats until both stages are full.

module bad_block_replacement_sequencer_core #(
    parameter int ADDR_WIDTH = bbr_seq_pkg::ADDR_WIDTH_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // bad_block[31:0], is_read_request[32], is_internal[33], rec_num[65:34],
    // data_addr[97:66], byte_count[129:98], residual[161:130], success[162],
    // part_offset[194:163], zero fill
    input  logic [bbr_seq_pkg::S_TDATA_W-1:0]     s_tdata,
    // command[0]
    input  logic [0:0]                            s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // block_no[31:0], out_rec_num[63:32], out_data_addr[95:64],
    // out_byte_count[127:96], out_residual[159:128], read_op[160],
    // clear_error[161], active[162], zero fill
    output logic [bbr_seq_pkg::M_TDATA_W-1:0]     m_tdata,
    // action[2:0]
    output logic [2:0]                            m_tuser,
    input  logic                                  cfg_wen,
    input  logic [bbr_seq_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bbr_seq_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import bbr_seq_pkg::*;

    cfg_t      cfg_reg;
    in_item_t  s_item;
    in_item_t  in_item;
    logic      in_valid;
    logic      out_can_load;
    logic      proc;
    res_item_t step_res;
    res_item_t m_res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.retry_limit <= RETRY_LIMIT_RST;
            cfg_reg.bbr_disable <= 1'b0;
            cfg_reg.block_shift <= BLOCK_SHIFT_RST;
        end else if (cfg_wen) begin
            unique case (cfg_index)
                REG_RETRY_LIMIT: cfg_reg.retry_limit <= cfg_wdata;
                REG_BBR_DISABLE: cfg_reg.bbr_disable <= cfg_wdata[0];
                REG_BLOCK_SHIFT: cfg_reg.block_shift <= cfg_wdata[4:0];
                default: ;
            endcase
        end
    end

    assign s_item.command         = s_tuser[0];
    assign s_item.bad_block       = s_tdata[31:0];
    assign s_item.is_read_request = s_tdata[32];
    assign s_item.is_internal     = s_tdata[33];
    assign s_item.rec_num         = s_tdata[65:34];
    assign s_item.data_addr       = s_tdata[97:66];
    assign s_item.byte_count      = s_tdata[129:98];
    assign s_item.residual        = s_tdata[161:130];
    assign s_item.success         = s_tdata[162];
    assign s_item.part_offset     = s_tdata[194:163];

    assign proc = in_valid && out_can_load;

    bbr_seq_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_item   (s_item),
        .take     (proc),
        .valid    (in_valid),
        .item     (in_item)
    );

    bbr_seq_engine #(
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .fire    (proc),
        .item    (in_item),
        .res     (step_res)
    );

    bbr_seq_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (proc),
        .res      (step_res),
        .can_load (out_can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_res    (m_res)
    );

    assign m_tuser = m_res.action;
    assign m_tdata = {5'b0, m_res.active, m_res.clear_error, m_res.read_op,
                      m_res.out_residual, m_res.out_byte_count, m_res.out_data_addr,
                      m_res.out_rec_num, m_res.block_no};

    // Only a reassign names a block
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != ACT_REASSIGN) |-> (m_tdata[31:0] == 32'd0))
        else $error("block_no set on a non-reassign action");

    // Restart and give up end the recovery
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == ACT_RESTART || m_tuser == ACT_GIVE_UP))
            |-> !m_tdata[162])
        else $error("recovery still active after it ended");

    // A processed beat always reaches the result register
    assert property (@(posedge aclk) disable iff (!aresetn)
        proc |=> m_tvalid)
        else $error("processed beat lost");

    // No action code beyond protocol error
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser <= ACT_PROTOCOL))
        else $error("undefined action code");

endmodule

// File: verif/tb_bad_block_replacement_sequencer_core.sv
`timescale 1ns / 1ps

module tb_bad_block_replacement_sequencer_core;

    import bbr_seq_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD   = 300;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // bad_block, is_read_request, is_internal, rec_num, data_addr, byte_count,
    // residual, success, part_offset, zero fill
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    // command
    logic [0:0]             s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // block_no, out_rec_num, out_data_addr, out_byte_count, out_residual,
    // read_op, clear_error, active, zero fill
    logic [M_TDATA_W-1:0]   m_tdata;
    // action
    logic [2:0]             m_tuser;
    logic                   cfg_wen = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    bad_block_replacement_sequencer_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // Register mirror
    logic [7:0]  lim_cfg   = RETRY_LIMIT_RST;
    logic        dis_cfg   = 1'b0;
    logic [4:0]  shift_cfg = BLOCK_SHIFT_RST;

    // Recovery state mirror
    logic [2:0]  rec_phase = PH_IDLE;
    logic [31:0] bb_store  = '0;
    logic [8:0]  retries   = '0;
    logic [31:0] sv_rec    = '0;
    logic [31:0] sv_addr   = '0;
    logic [31:0] sv_count  = '0;
    logic [31:0] sv_resid  = '0;
    logic        sv_read   = 1'b0;
    logic [31:0] wb_rec    = '0;
    logic [31:0] wb_addr   = '0;

    in_item_t    pending_beats[$];
    res_item_t   due_actions[$];
    in_item_t    drv_item;
    int          queued = 0;
    int          fail_count = 0;
    int          drv_gap = 0;
    int          mon_gap = 0;
    int          hold_left = 0;
    int          stall_cycles = 0;
    bit          idle_en = 1'b1;
    bit          hold_req = 1'b0;
    bit          hold_done = 1'b0;

    // End of recovery: restore the request, rewind it on success
    function automatic res_item_t end_recovery(logic ok, logic clr);
        res_item_t r;
        r = '0;
        rec_phase = PH_IDLE;
        r.out_rec_num    = sv_rec;
        r.out_data_addr  = sv_addr;
        r.out_byte_count = sv_count;
        r.out_residual   = sv_resid;
        r.read_op        = sv_read;
        if (ok) begin
            r.action      = ACT_RESTART;
            r.clear_error = 1'b1;
            if (sv_resid != 0) begin
                r.out_data_addr  = sv_addr - sv_resid;
                r.out_byte_count = sv_count + sv_resid;
                r.out_rec_num    = sv_rec - (sv_resid >> shift_cfg);
                r.out_residual   = '0;
            end
        end else begin
            r.action      = ACT_GIVE_UP;
            r.clear_error = clr;
        end
        return r;
    endfunction

    function automatic res_item_t write_back_beat();
        res_item_t r;
        r = '0;
        r.action         = ACT_WRITE;
        r.out_rec_num    = wb_rec;
        r.out_data_addr  = wb_addr;
        r.out_byte_count = 32'd1 << shift_cfg;
        return r;
    endfunction

    function automatic res_item_t next_action(in_item_t it);
        res_item_t   r;
        logic [31:0] tmp;
        logic [31:0] delta;
        logic [8:0]  prior;
        r = '0;
        if (it.command == CMD_START) begin
            if (dis_cfg || it.is_internal) begin
                r.action = ACT_DECLINED;
            end else begin
                bb_store = it.bad_block;
                retries  = '0;
                sv_rec   = it.rec_num;
                sv_addr  = it.data_addr;
                sv_count = it.byte_count;
                sv_resid = it.residual;
                sv_read  = it.is_read_request;
                r.out_rec_num    = it.rec_num;
                r.out_data_addr  = it.data_addr;
                r.out_byte_count = it.byte_count;
                if (!it.is_read_request) begin
                    rec_phase      = PH_COMPLETE;
                    r.action       = ACT_REASSIGN;
                    r.block_no     = it.bad_block;
                    r.out_residual = it.residual;
                end else begin
                    rec_phase = PH_RETRY_READ;
                    r.action  = ACT_READ;
                    r.read_op = 1'b1;
                end
            end
        end else begin
            case (rec_phase)
                PH_COMPLETE: begin
                    r = end_recovery(it.success, 1'b0);
                end
                PH_RETRY_READ: begin
                    if (it.success) begin
                        retries   = '0;
                        rec_phase = PH_COPY;
                        r.action         = ACT_REASSIGN;
                        r.block_no       = bb_store;
                        r.out_rec_num    = sv_rec;
                        r.out_data_addr  = sv_addr;
                        r.out_byte_count = sv_count;
                        r.read_op        = 1'b1;
                    end else begin
                        prior   = retries;
                        retries = retries + 9'd1;
                        if (prior < lim_cfg) begin
                            r.action         = ACT_READ;
                            r.out_rec_num    = sv_rec;
                            r.out_data_addr  = sv_addr;
                            r.out_byte_count = sv_count;
                            r.read_op        = 1'b1;
                        end else begin
                            r = end_recovery(1'b0, 1'b0);
                        end
                    end
                end
                PH_COPY: begin
                    if (it.success) begin
                        tmp       = bb_store - it.part_offset;
                        delta     = tmp - sv_rec;
                        wb_rec    = tmp;
                        wb_addr   = sv_addr + (delta << shift_cfg);
                        rec_phase = PH_VERIFY;
                        r = write_back_beat();
                    end else begin
                        r = end_recovery(1'b0, 1'b1);
                    end
                end
                PH_VERIFY: begin
                    if (it.success) begin
                        r = end_recovery(1'b1, 1'b0);
                    end else begin
                        prior   = retries;
                        retries = retries + 9'd1;
                        if (prior > lim_cfg)
                            r = end_recovery(1'b0, 1'b0);
                        else
                            r = write_back_beat();
                    end
                end
                default: begin
                    r.action = ACT_PROTOCOL;
                end
            endcase
        end
        r.active = (rec_phase != PH_IDLE);
        return r;
    endfunction

    function automatic logic [S_TDATA_W-1:0] pack_beat(in_item_t it);
        logic [S_TDATA_W-1:0] d;
        d = '0;
        d[31:0]    = it.bad_block;
        d[32]      = it.is_read_request;
        d[33]      = it.is_internal;
        d[65:34]   = it.rec_num;
        d[97:66]   = it.data_addr;
        d[129:98]  = it.byte_count;
        d[161:130] = it.residual;
        d[162]     = it.success;
        d[194:163] = it.part_offset;
        return d;
    endfunction

    function automatic in_item_t start_beat(logic rd, logic internal, logic [31:0] blk,
                                            logic [31:0] rec, logic [31:0] addr,
                                            logic [31:0] cnt, logic [31:0] res);
        in_item_t it;
        it.command         = CMD_START;
        it.bad_block       = blk;
        it.is_read_request = rd;
        it.is_internal     = internal;
        it.rec_num         = rec;
        it.data_addr       = addr;
        it.byte_count      = cnt;
        it.residual        = res;
        it.success         = 1'($urandom_range(0, 1));
        it.part_offset     = $urandom;
        return it;
    endfunction

    function automatic in_item_t rand_start(logic rd);
        logic [31:0] res;
        res = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
        return start_beat(rd, 1'b0, $urandom, $urandom, $urandom, $urandom, res);
    endfunction

    // Completion beat; the start-only fields carry noise
    function automatic in_item_t done_beat(logic ok, logic [31:0] part);
        in_item_t it;
        it = start_beat(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom,
                        $urandom, $urandom, $urandom, $urandom);
        it.command     = CMD_DONE;
        it.success     = ok;
        it.part_offset = part;
        return it;
    endfunction

    task automatic queue_beat(in_item_t it);
        pending_beats.push_back(it);
        queued++;
    endtask

    // Well-formed recovery with random retry counts around the limit
    task automatic queue_recovery();
        logic rd;
        int   cap;
        int   n_fail;
        rd = 1'($urandom_range(0, 1));
        queue_beat(rand_start(rd));
        if (!rd) begin
            queue_beat(done_beat($urandom_range(0, 3) != 0, $urandom));
        end else begin
            cap    = (lim_cfg < 12) ? lim_cfg + 1 : 8;
            n_fail = $urandom_range(0, cap);
            repeat (n_fail) queue_beat(done_beat(1'b0, $urandom));
            if (n_fail <= lim_cfg) begin
                queue_beat(done_beat(1'b1, $urandom));
                if ($urandom_range(0, 7) == 0) begin
                    queue_beat(done_beat(1'b0, $urandom));
                end else begin
                    cap    = (lim_cfg < 12) ? lim_cfg + 2 : 8;
                    n_fail = $urandom_range(0, cap);
                    repeat (n_fail) queue_beat(done_beat(1'b0, $urandom));
                    if (n_fail <= lim_cfg + 1)
                        queue_beat(done_beat(1'b1, $urandom));
                end
            end
        end
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_RETRY_LIMIT: lim_cfg = val;
            REG_BBR_DISABLE: dis_cfg = val[0];
            REG_BLOCK_SHIFT: shift_cfg = val[4:0];
            default: ;
        endcase
    endtask

    task automatic wait_drain();
        do @(negedge aclk);
        while (pending_beats.size() != 0 || s_tvalid || due_actions.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic run_phase(logic [7:0] lim, logic dis, logic [4:0] shift, int n_beats);
        int       first;
        int       sel;
        in_item_t it;
        write_reg(REG_RETRY_LIMIT, lim);
        write_reg(REG_BBR_DISABLE, {7'd0, dis});
        write_reg(REG_BLOCK_SHIFT, {3'd0, shift});
        @(posedge aclk);
        cfg_wen <= 1'b0;
        @(negedge aclk);
        first = queued;
        while (queued - first < n_beats) begin
            sel = $urandom_range(0, 99);
            if (sel < 78) begin
                queue_recovery();
            end else if (sel < 86) begin
                queue_beat(done_beat(1'($urandom_range(0, 1)), $urandom));
            end else if (sel < 93) begin
                it = rand_start(1'($urandom_range(0, 1)));
                it.is_internal = 1'b1;
                queue_beat(it);
            end else begin
                // abandon a recovery part way through
                queue_beat(rand_start(1'($urandom_range(0, 1))));
                repeat ($urandom_range(0, 2))
                    queue_beat(done_beat(1'($urandom_range(0, 1)), $urandom));
            end
        end
        wait_drain();
    endtask

    task automatic report_field(string fld, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, fld, want, got);
            fail_count++;
        end
    endtask

    // Driver: offer queued beats, predict at acceptance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                due_actions.push_back(next_action(drv_item));
            if (!s_tvalid || s_tready) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_beats.size() == 0) begin
                    s_tvalid <= 1'b0;
                end else if (idle_en && $urandom_range(0, 99) < 20) begin
                    drv_gap = $urandom_range(0, 2);
                    s_tvalid <= 1'b0;
                end else begin
                    drv_item = pending_beats.pop_front();
                    s_tdata  <= pack_beat(drv_item);
                    s_tuser  <= drv_item.command;
                    s_tvalid <= 1'b1;
                end
            end
        end
    end

    // Monitor: check each result beat, throttle m_tready
    always @(posedge aclk) begin
        res_item_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (due_actions.size() == 0) begin
                    $display("%0t: unexpected result, expected none actual %h %h",
                             $time, m_tuser, m_tdata);
                    fail_count++;
                end else begin
                    want = due_actions.pop_front();
                    report_field("action", 32'(want.action), 32'(m_tuser));
                    report_field("block_no", want.block_no, m_tdata[31:0]);
                    report_field("out_rec_num", want.out_rec_num, m_tdata[63:32]);
                    report_field("out_data_addr", want.out_data_addr, m_tdata[95:64]);
                    report_field("out_byte_count", want.out_byte_count, m_tdata[127:96]);
                    report_field("out_residual", want.out_residual, m_tdata[159:128]);
                    report_field("read_op", 32'(want.read_op), 32'(m_tdata[160]));
                    report_field("clear_error", 32'(want.clear_error), 32'(m_tdata[161]));
                    report_field("active", 32'(want.active), 32'(m_tdata[162]));
                end
            end
            if (hold_req && !hold_done) begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (mon_gap > 0) begin
                mon_gap--;
                m_tready <= 1'b0;
            end else if (idle_en && $urandom_range(0, 99) < 20) begin
                mon_gap = $urandom_range(0, 2);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: count cycles without any accepted beat
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("bad_block_replacement_sequencer_core regression: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed, reset register values
        queue_beat(done_beat(1'b0, 32'd0));
        queue_beat(done_beat(1'b1, 32'hFFFF_FFFF));
        queue_beat(start_beat(1'b1, 1'b1, $urandom, $urandom, $urandom, $urandom, $urandom));
        queue_beat(start_beat(1'b0, 1'b1, $urandom, $urandom, $urandom, $urandom, $urandom));
        // write path, rewind wraps the address below zero
        queue_beat(start_beat(1'b0, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0100,
                              32'hFFFF_FFFF, 32'h0000_0600));
        queue_beat(done_beat(1'b1, $urandom));
        queue_beat(start_beat(1'b0, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0));
        queue_beat(done_beat(1'b0, $urandom));
        // read retries, then reassign fails after a good read
        queue_beat(start_beat(1'b1, 1'b0, 32'h0000_1234, 32'd0, 32'd0, 32'd0, 32'd0));
        queue_beat(done_beat(1'b0, $urandom));
        queue_beat(done_beat(1'b0, $urandom));
        queue_beat(done_beat(1'b1, $urandom));
        queue_beat(done_beat(1'b0, $urandom));
        // full copy with verify retries
        queue_beat(start_beat(1'b1, 1'b0, 32'hFFFF_FFFF, 32'd5, 32'hFFFF_F000,
                              32'h0000_0800, 32'h0000_0200));
        queue_beat(done_beat(1'b1, 32'd0));
        queue_beat(done_beat(1'b1, 32'hFFFF_FFFF));
        queue_beat(done_beat(1'b0, $urandom));
        queue_beat(done_beat(1'b0, $urandom));
        queue_beat(done_beat(1'b1, $urandom));
        // a new start abandons the running recovery
        queue_beat(rand_start(1'b1));
        queue_beat(rand_start(1'b0));
        queue_beat(done_beat(1'b1, $urandom));
        wait_drain();

        // Random phases; hold the result side off early in the first
        hold_req = 1'b1;
        run_phase(8'd3, 1'b0, 5'd12, 80);
        run_phase(8'd0, 1'b0, 5'd16, 80);
        run_phase(8'd255, 1'b0, 5'd9, 80);
        run_phase(8'd5, 1'b1, 5'd13, 40);
        run_phase(8'd1, 1'b0, 5'd10, 80);
        idle_en = 1'b0;
        run_phase(8'($urandom_range(0, 15)), 1'b0, 5'($urandom_range(9, 16)), 80);

        repeat (10) @(posedge aclk);
        if (fail_count == 0)
            $display("bad_block_replacement_sequencer_core regression: pass");
        else
            $display("bad_block_replacement_sequencer_core regression: fail");
        $finish;
    end

endmodule

// File: files.f
design/bbr_seq_pkg.sv
design/bbr_seq_in_stage.sv
design/bbr_seq_engine.sv
design/bbr_seq_out_stage.sv
design/bad_block_replacement_sequencer_core.sv
verif/tb_bad_block_replacement_sequencer_core.sv
